>>> rtl/lpb_pkg.sv
// Package: shared types, constants and the CORDIC arctangent table.
`default_nettype none
package lpb_pkg;

    localparam int TAB_LEN = 24;
    localparam int IDX_W   = 5;
    localparam int SQRT_BITS = 12;
    localparam int DEG_ONE = 65536;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             load;
        logic             cordic_en;
        logic             sqrt_en;
        logic [IDX_W-1:0] idx;
        logic             finish;
    } cmd_t;

    function automatic logic [22:0] atan_q16(input logic [IDX_W-1:0] i);
        logic [22:0] v;
        case (i)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117305;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/lpb_ctrl.sv
// Controller: sequences load, CORDIC and square-root steps, finish and result hold.
`default_nettype none
module lpb_ctrl #(
    parameter int CORDIC_ITERS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output lpb_pkg::cmd_t     cmd
);
    import lpb_pkg::*;

    localparam int ITERS_EFF = (CORDIC_ITERS < TAB_LEN) ? CORDIC_ITERS : TAB_LEN;
    localparam int STEPS     = (ITERS_EFF > SQRT_BITS) ? ITERS_EFF : SQRT_BITS;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (in_valid) state_next = ST_RUN;
            end
            ST_RUN: begin
                step_next = step_reg + 1'b1;
                if (step_reg == IDX_W'(STEPS - 1)) state_next = ST_FIN;
            end
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd           = '0;
        cmd.idx       = step_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN: begin
                cmd.cordic_en = (step_reg < IDX_W'(ITERS_EFF));
                cmd.sqrt_en   = (step_reg < IDX_W'(SQRT_BITS));
            end
            ST_FIN:  cmd.finish = 1'b1;
            ST_DONE: out_valid = 1'b1;
            default: ;
        endcase
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready and result valid together");
    a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("load not followed by first step");
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finish not followed by result");

endmodule
`default_nettype wire

>>> rtl/lpb_datapath.sv
// Datapath: window test, slot count, vectoring CORDIC, bitwise square root.
`default_nettype none
module lpb_datapath #(
    parameter int MAX_POINTS = 271
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lpb_pkg::cmd_t cmd,
    input  wire logic        first_of_scan,
    input  wire logic signed [15:0] x_mm,
    input  wire logic signed [15:0] y_mm,
    output logic             in_window,
    output logic [8:0]       slot,
    output logic             overflow,
    output logic             bin_valid,
    output logic [8:0]       bin_index,
    output logic [11:0]      range_mm
);
    import lpb_pkg::*;

    localparam logic signed [26:0] D45  = 27'(45 * DEG_ONE);
    localparam logic signed [26:0] D90  = 27'(90 * DEG_ONE);
    localparam logic signed [26:0] D135 = 27'(135 * DEG_ONE);
    localparam logic signed [26:0] D180 = 27'(180 * DEG_ONE);
    localparam logic signed [26:0] D270 = 27'(270 * DEG_ONE);

    logic [8:0] count_reg;
    logic       win_reg, swp_reg, xneg_reg, yneg_reg, lo0_reg, eq_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [24:0] cz_reg;
    logic [22:0] n_reg;
    logic [11:0] r_reg;

    // load-time decode
    logic        win_in;
    logic [15:0] axw, ayw;
    logic [11:0] ax, ay, hi, lo;
    logic        swp;
    logic [8:0]  cnt_base;
    logic        ovf_in;

    always_comb begin
        win_in   = (x_mm >= -16'sd1999) && (x_mm <= 16'sd2003) &&
                   (y_mm >= -16'sd1999) && (y_mm <= 16'sd2003);
        axw      = x_mm[15] ? 16'(-x_mm) : x_mm;
        ayw      = y_mm[15] ? 16'(-y_mm) : y_mm;
        ax       = axw[11:0];
        ay       = ayw[11:0];
        swp      = ay > ax;
        hi       = swp ? ay : ax;
        lo       = swp ? ax : ay;
        cnt_base = first_of_scan ? 9'd0 : count_reg;
        ovf_in   = cnt_base >= 9'(MAX_POINTS);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
        end else if (cmd.load) begin
            count_reg <= (win_in && !ovf_in) ? cnt_base + 9'd1 : cnt_base;
        end
    end

    // CORDIC step and square-root bit step
    logic signed [33:0] sx, sy;
    logic [11:0] rt;
    logic [23:0] rt_sq;

    always_comb begin
        sx    = cx_reg >>> cmd.idx;
        sy    = cy_reg >>> cmd.idx;
        rt    = r_reg | (12'd1 << (4'(SQRT_BITS - 1) - cmd.idx[3:0]));
        rt_sq = rt * rt;
    end

    // final angle assembly
    logic signed [26:0] zc, a, a0, t, deg;
    always_comb begin
        if (cz_reg < 0)                    zc = '0;
        else if (27'(cz_reg) > D45)        zc = D45;
        else                               zc = 27'(cz_reg);
        a   = lo0_reg ? '0 : (eq_reg ? D45 : zc);
        a0  = swp_reg ? D90 - a : a;
        if (!yneg_reg) t = xneg_reg ? D180 - a0 : a0;
        else           t = xneg_reg ? a0 - D180 : -a0;
        deg = t + D135;
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            win_reg   <= win_in;
            slot      <= win_in ? cnt_base : 9'd0;
            overflow  <= win_in && ovf_in;
            swp_reg   <= swp;
            xneg_reg  <= x_mm[15];
            yneg_reg  <= y_mm[15];
            lo0_reg   <= (lo == 12'd0);
            eq_reg    <= (lo == hi);
            cx_reg    <= $signed({2'b00, hi, 20'd0});
            cy_reg    <= $signed({2'b00, lo, 20'd0});
            cz_reg    <= '0;
            n_reg     <= 23'(ax * ax) + 23'(ay * ay);
            r_reg     <= '0;
        end else begin
            if (cmd.cordic_en) begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + sy;
                    cy_reg <= cy_reg - sx;
                    cz_reg <= cz_reg + $signed({2'b00, atan_q16(cmd.idx)});
                end else begin
                    cx_reg <= cx_reg - sy;
                    cy_reg <= cy_reg + sx;
                    cz_reg <= cz_reg - $signed({2'b00, atan_q16(cmd.idx)});
                end
            end
            if (cmd.sqrt_en && (rt_sq <= {1'b0, n_reg})) r_reg <= rt;
        end
        if (cmd.finish) begin
            in_window <= win_reg;
            if (win_reg && deg >= 0 && deg <= D270) begin
                bin_valid <= 1'b1;
                bin_index <= deg[24:16];
            end else begin
                bin_valid <= 1'b0;
                bin_index <= '0;
            end
            range_mm <= win_reg ? r_reg : 12'd0;
        end
    end

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 9'(MAX_POINTS))
        else $error("slot count past limit");
    a_ovf_win: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish) && overflow |-> in_window)
        else $error("overflow outside window");
    a_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish) && !bin_valid |-> bin_index == 9'd0)
        else $error("bin index without valid");

endmodule
`default_nettype wire

>>> rtl/lidar_point_window_polar_binner.sv
// Top level: lidar point window test, slot count and polar binning.
// Sequence: accept, then the CORDIC and square-root steps (CORDIC_ITERS is capped at 24),
// a finish step, then the result is held until taken.
// One point at a time: a new point is accepted only after the previous result is taken.
// Reset: rst_n asynchronous active low clears the slot count and the controller.
`default_nettype none
module lidar_point_window_polar_binner #(
    parameter int MAX_POINTS   = 271,
    parameter int CORDIC_ITERS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        first_of_scan,
    input  wire logic signed [15:0] x_mm,
    input  wire logic signed [15:0] y_mm,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             in_window,
    output logic [8:0]       slot,
    output logic             overflow,
    output logic             bin_valid,
    output logic [8:0]       bin_index,
    output logic [11:0]      range_mm
);
    import lpb_pkg::*;

    // command bundle from the sequencer to the datapath
    cmd_t cmd;

    // sequence one request: load, iterate, finish, hold until taken
    lpb_ctrl #(.CORDIC_ITERS(CORDIC_ITERS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // window test and count at load; angle and range over the step cycles
    lpb_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .first_of_scan (first_of_scan),
        .x_mm          (x_mm),
        .y_mm          (y_mm),
        .in_window     (in_window),
        .slot          (slot),
        .overflow      (overflow),
        .bin_valid     (bin_valid),
        .bin_index     (bin_index),
        .range_mm      (range_mm)
    );

endmodule
`default_nettype wire

>>> dv/lidar_point_window_polar_binner_tb.sv
// Testbench for the lidar point window and polar binner: directed and random points vs a predictor.
`default_nettype none
module lidar_point_window_polar_binner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POINTS   = 271;
    localparam int CORDIC_ITERS = 16;
    localparam int STALL_LIMIT  = 20000;
    localparam int N_RANDOM     = 700;

    typedef struct packed {
        logic       in_window;
        logic [8:0] slot;
        logic       overflow;
        logic       bin_valid;
        logic [8:0] bin_index;
        logic [11:0] range_mm;
    } bin_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic first_of_scan = 1'b0;
    logic signed [15:0] x_mm = '0;
    logic signed [15:0] y_mm = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic in_window, overflow, bin_valid;
    logic [8:0] slot, bin_index;
    logic [11:0] range_mm;

    // Predictor state: slot count of the current scan.
    int unsigned scan_count;
    bin_result_t expected_bins[$];
    int errors = 0;
    int points_sent = 0;
    int results_seen = 0;
    int in_window_seen = 0;
    int overflow_seen = 0;
    int idle_cycles = 0;
    int ready_hold = 0;

    always #1 clk = ~clk;

    lidar_point_window_polar_binner #(
        .MAX_POINTS  (MAX_POINTS),
        .CORDIC_ITERS(CORDIC_ITERS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_of_scan(first_of_scan),
        .x_mm         (x_mm),
        .y_mm         (y_mm),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .in_window    (in_window),
        .slot         (slot),
        .overflow     (overflow),
        .bin_valid    (bin_valid),
        .bin_index    (bin_index),
        .range_mm     (range_mm)
    );

    // Shift right rounding toward minus infinity.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step_q16(int i);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    // Vectoring CORDIC on (hi, lo), 0 < lo < hi; angle in Q16 degrees clamped to [0, 45].
    function automatic longint octant_deg_q16(longint hi, longint lo);
        longint cx, cy, z, xo;
        cx = hi * 1048576;
        cy = lo * 1048576;
        z = 0;
        for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
            xo = cx;
            if (cy > 0) begin
                cx += floor_shift(cy, i);
                cy -= floor_shift(xo, i);
                z += atan_step_q16(i);
            end else begin
                cx -= floor_shift(cy, i);
                cy += floor_shift(xo, i);
                z -= atan_step_q16(i);
            end
        end
        if (z < 0) z = 0;
        if (z > 45 * 65536) z = 45 * 65536;
        return z;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = longint'(1) << 30;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Work out the result for one point and advance the scan count.
    function automatic bin_result_t predict_bin(logic fos, logic signed [15:0] xi,
                                                 logic signed [15:0] yi);
        bin_result_t r;
        longint px, py, ax, ay, hi, lo, a, a0, t, deg;
        logic swapped;
        r = '0;
        px = xi;
        py = yi;
        if (fos) scan_count = 0;
        if (px < -1999 || px > 2003 || py < -1999 || py > 2003) return r;
        r.in_window = 1'b1;
        r.slot = scan_count[8:0];
        if (scan_count >= MAX_POINTS) r.overflow = 1'b1;
        else scan_count = (scan_count + 1) & 9'h1FF;
        ax = px < 0 ? -px : px;
        ay = py < 0 ? -py : py;
        swapped = ay > ax;
        hi = swapped ? ay : ax;
        lo = swapped ? ax : ay;
        if (lo == 0) a = 0;
        else if (lo == hi) a = 45 * 65536;
        else a = octant_deg_q16(hi, lo);
        a0 = swapped ? 90 * 65536 - a : a;
        if (py >= 0) t = (px >= 0) ? a0 : 180 * 65536 - a0;
        else t = (px >= 0) ? -a0 : -(180 * 65536 - a0);
        deg = t + 135 * 65536;
        if (deg >= 0 && deg <= 270 * 65536) begin
            r.bin_valid = 1'b1;
            r.bin_index = 9'(floor_shift(deg, 16));
        end
        r.range_mm = 12'(int_sqrt(px * px + py * py));
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(3);
        return $urandom_range(60);
    endfunction

    // Send one request; hold valid and payload until accepted.
    // Drop valid only when a gap comes before a request, so back-to-back requests keep it high.
    task automatic send_point(logic fos, logic signed [15:0] xi, logic signed [15:0] yi);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_of_scan <= fos;
        x_mm <= xi;
        y_mm <= yi;
        do @(posedge clk); while (!in_ready);
        expected_bins.push_back(predict_bin(fos, xi, yi));
        points_sent++;
    endtask

    function automatic logic signed [15:0] window_coord();
        return 16'($signed($urandom_range(4005)) - 2001);
    endfunction

    task automatic test_directed();
        send_point(1'b1, 16'sd0, 16'sd0);
        send_point(1'b0, -16'sd1999, -16'sd1999);
        send_point(1'b0, 16'sd2003, 16'sd2003);
        send_point(1'b0, -16'sd2000, 16'sd0);
        send_point(1'b0, 16'sd2004, 16'sd0);
        send_point(1'b0, 16'sd0, 16'sd2004);
        send_point(1'b0, 16'sh7FFF, 16'sh8000);
        send_point(1'b0, 16'sh8000, 16'sh7FFF);
        send_point(1'b0, -16'sd1000, 16'sd0);
        send_point(1'b0, -16'sd1000, -16'sd1);
        send_point(1'b0, 16'sd0, -16'sd1500);
        send_point(1'b0, 16'sd0, 16'sd1500);
        send_point(1'b0, -16'sd700, -16'sd700);
        send_point(1'b0, 16'sd700, -16'sd300);
        send_point(1'b0, -16'sd5, 16'sd1999);
        send_point(1'b0, -16'sd1999, -16'sd1);
        send_point(1'b1, 16'sd12, 16'sd34);
    endtask

    // Long scan past the slot limit, then a fresh scan clears the count.
    task automatic test_slot_overflow();
        for (int i = 0; i < MAX_POINTS + 6; i++)
            send_point(i == 0, window_coord(), window_coord());
        send_point(1'b1, window_coord(), window_coord());
    endtask

    task automatic test_random_points();
        int p;
        for (int i = 0; i < N_RANDOM; i++) begin
            p = $urandom_range(99);
            if (p < 75)
                send_point($urandom_range(99) < 3, window_coord(), window_coord());
            else if (p < 90)
                send_point($urandom_range(1), 16'($urandom), 16'($urandom));
            else
                send_point(1'b0, 16'($signed($urandom_range(8)) - 4),
                           16'($signed($urandom_range(8)) - 4));
        end
    endtask

    // Random back-pressure on the result side: short gaps, rare long holds,
    // and calm stretches.
    always @(posedge clk) begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold != 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if ((results_seen / 200) % 3 == 2) out_ready <= 1'b1;
        else
        begin
            out_ready <= ($urandom_range(99) < 60);
            if ($urandom_range(99) < 2) ready_hold <= $urandom_range(40);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk) begin
        bin_result_t e;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_bins.size() == 0) begin
                $error("result with no pending request");
                errors++;
            end else begin
                e = expected_bins.pop_front();
                if (e.in_window) in_window_seen++;
                if (e.overflow) overflow_seen++;
                if (in_window !== e.in_window) begin
                    $error("in_window exp %0d got %0d", e.in_window, in_window); errors++;
                end
                if (slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, slot); errors++;
                end
                if (overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, overflow); errors++;
                end
                if (bin_valid !== e.bin_valid) begin
                    $error("bin_valid exp %0d got %0d", e.bin_valid, bin_valid); errors++;
                end
                if (bin_index !== e.bin_index) begin
                    $error("bin_index exp %0d got %0d", e.bin_index, bin_index); errors++;
                end
                if (range_mm !== e.range_mm) begin
                    $error("range_mm exp %0d got %0d", e.range_mm, range_mm); errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted request on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("lidar_point_window_polar_binner_tb: FAIL");
            $finish;
        end
    end

    initial begin
        scan_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_slot_overflow();
        test_random_points();
        in_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d points, checked %0d results (%0d in window, %0d overflow).",
                 points_sent, results_seen, in_window_seen, overflow_seen);
        if (errors == 0 && expected_bins.size() == 0)
            $display("lidar_point_window_polar_binner_tb: PASS");
        else
            $display("lidar_point_window_polar_binner_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/lpb_pkg.sv
rtl/lpb_ctrl.sv
rtl/lpb_datapath.sv
rtl/lidar_point_window_polar_binner.sv
dv/lidar_point_window_polar_binner_tb.sv
